/* hdl/alsc_pkg.sv */
// ---------------------------------------------------------------------------
// alsc_pkg: shared types and constants for the alarm scheduler
// Command, status and event codes, table geometry, beat field positions.
// ---------------------------------------------------------------------------
package alsc_pkg;

    localparam int SLOT_COUNT = 9;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W      = 4;

    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;
    localparam int NEW_W  = 7;

    // Commands
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_ADD    = 3'd1;
    localparam logic [2:0] CMD_DEL    = 3'd2;
    localparam logic [2:0] CMD_OFF    = 3'd3;
    localparam logic [2:0] CMD_SNOOZE = 3'd4;
    localparam logic [2:0] CMD_READ   = 3'd5;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_BADTIME = 3'd2;
    localparam logic [2:0] ST_BADNUM  = 3'd3;
    localparam logic [2:0] ST_BUSY    = 3'd4;

    // Event codes
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_START   = 3'd1;
    localparam logic [2:0] EV_KEY     = 3'd2;
    localparam logic [2:0] EV_TIMEOUT = 3'd3;
    localparam logic [2:0] EV_SNOOZE  = 3'd4;
    localparam logic [2:0] EV_RESUME  = 3'd5;

    // Configuration register indexes
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_SNOOZE  = 1'b1;

    localparam logic [SEC_W-1:0] SEC_MAX       = 6'd59;
    localparam logic [SEC_W:0]   SEC_PER_MIN   = 7'd60;
    localparam logic [NEW_W-1:0] HOURS_PER_DAY = 7'd24;
    localparam logic [NEW_W-1:0] MIN_PER_HOUR  = 7'd60;
    localparam logic [5:0]       TIMEOUT_RESET = 6'd10;
    localparam logic [7:0]       SNOOZE_RESET  = 8'd10;

    // Output beat field positions
    localparam int OUT_STATUS_LSB = 0;
    localparam int OUT_EVENT_LSB  = 3;
    localparam int OUT_RING_BIT   = 6;
    localparam int OUT_RNUM_LSB   = 7;
    localparam int OUT_COUNT_LSB  = 11;
    localparam int OUT_HOUR_LSB   = 15;
    localparam int OUT_MIN_LSB    = 20;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } ctl_state_t;

    typedef struct packed {
        logic             append;
        logic             remove;
        logic [IDX_W-1:0] pos;
    } tbl_req_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [HOUR_W-1:0] rd_hour;
        logic [MIN_W-1:0]  rd_minute;
    } tbl_rsp_t;

endpackage

/* hdl/alsc_cell.sv */
// ---------------------------------------------------------------------------
// alsc_cell: one alarm table entry
// Holds one hour:minute, loads a new entry or takes its upper neighbor's entry,
// and joins the first-match chain that runs along the row.
// ---------------------------------------------------------------------------
module alsc_cell
    import alsc_pkg::*;
(
    input  logic              clk,
    input  cell_op_t          op,
    input  logic [HOUR_W-1:0] load_hour,
    input  logic [MIN_W-1:0]  load_minute,
    input  logic [HOUR_W-1:0] nbr_hour,
    input  logic [MIN_W-1:0]  nbr_minute,
    input  logic [HOUR_W-1:0] cmp_hour,
    input  logic [MIN_W-1:0]  cmp_minute,
    input  logic              occupied,
    input  logic              found_in,
    output logic [HOUR_W-1:0] hour,
    output logic [MIN_W-1:0]  minute,
    output logic              found_out,
    output logic              hit
);

    logic [HOUR_W-1:0] hour_reg, hour_next;
    logic [MIN_W-1:0]  minute_reg, minute_next;
    logic              match;

    always_comb
    begin
        hour_next   = hour_reg;
        minute_next = minute_reg;
        unique case (op)
            CELL_LOAD:
            begin
                hour_next   = load_hour;
                minute_next = load_minute;
            end
            CELL_SHIFT:
            begin
                hour_next   = nbr_hour;
                minute_next = nbr_minute;
            end
            default:
            begin
                hour_next   = hour_reg;
                minute_next = minute_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
    end

    assign match     = occupied && (hour_reg == cmp_hour) && (minute_reg == cmp_minute);
    assign hit       = match && !found_in;
    assign found_out = found_in || match;
    assign hour      = hour_reg;
    assign minute    = minute_reg;

endmodule

/* hdl/alsc_table.sv */
// ---------------------------------------------------------------------------
// alsc_table: row of alarm cells
// Appends at the fill point, closes a gap by shifting upper entries down,
// finds the first entry equal to the clock and reads one entry by index.
// ---------------------------------------------------------------------------
module alsc_table
    import alsc_pkg::*;
(
    input  logic              clk,
    input  tbl_req_t          req,
    input  logic [CNT_W-1:0]  count,
    input  logic [HOUR_W-1:0] load_hour,
    input  logic [MIN_W-1:0]  load_minute,
    input  logic [HOUR_W-1:0] cmp_hour,
    input  logic [MIN_W-1:0]  cmp_minute,
    input  logic [IDX_W-1:0]  rd_idx,
    output tbl_rsp_t          rsp
);

    logic [HOUR_W-1:0] cell_hour   [SLOT_COUNT];
    logic [MIN_W-1:0]  cell_minute [SLOT_COUNT];
    logic [SLOT_COUNT:0]   found;
    logic [SLOT_COUNT-1:0] hit;
    cell_op_t              op [SLOT_COUNT];

    assign found[0] = 1'b0;

    for (genvar i = 0; i < SLOT_COUNT; i++)
    begin : g_cell
        localparam int NB = (i + 1 < SLOT_COUNT) ? i + 1 : i;

        always_comb
        begin
            op[i] = CELL_HOLD;
            if (req.append && (req.pos == IDX_W'(i)))
                op[i] = CELL_LOAD;
            else if (req.remove && (IDX_W'(i) >= req.pos) && (i + 1 < SLOT_COUNT))
                op[i] = CELL_SHIFT;
        end

        alsc_cell u_cell (
            .clk         (clk),
            .op          (op[i]),
            .load_hour   (load_hour),
            .load_minute (load_minute),
            .nbr_hour    (cell_hour[NB]),
            .nbr_minute  (cell_minute[NB]),
            .cmp_hour    (cmp_hour),
            .cmp_minute  (cmp_minute),
            .occupied    (CNT_W'(i) < count),
            .found_in    (found[i]),
            .hour        (cell_hour[i]),
            .minute      (cell_minute[i]),
            .found_out   (found[i+1]),
            .hit         (hit[i])
        );
    end

    always_comb
    begin
        rsp           = '0;
        rsp.hit       = found[SLOT_COUNT];
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (hit[i])
                rsp.hit_idx = IDX_W'(i);
            if (rd_idx == IDX_W'(i))
            begin
                rsp.rd_hour   = cell_hour[i];
                rsp.rd_minute = cell_minute[i];
            end
        end
    end

endmodule

/* hdl/multi_slot_alarm_scheduler.sv */
// ---------------------------------------------------------------------------
// multi_slot_alarm_scheduler: time-of-day alarm table with ring control
// Keeps up to SLOT_COUNT alarms and runs ring, timeout and snooze handling.
// ---------------------------------------------------------------------------
// Usage:
//   s_* carries one command beat (tick, add, delete, off, snooze, read).
//   m_* returns exactly one result beat per command, in order.
//   cfg_we/cfg_index/cfg_data write ring timeout (0) and snooze length (1);
//   write only while no command is in flight.
// Timing:
//   A command first has its beat captured; then the cell row shifts or loads
//   and the first-match chain along the row resolves while it executes.
//   The result is registered when the command retires; the next command is
//   taken once the block is idle again.
//   The result register lets the next beat in while a result waits; if the
//   receiver stalls longer, the block holds the second command until the
//   result register frees up.
// Reset:
//   Empties the table, stops any ring or snooze, restores timeout and snooze
//   to 10. Entries above the fill count are never read, so cells need none.
// ---------------------------------------------------------------------------
module multi_slot_alarm_scheduler
    import alsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd, now_hour, now_minute, now_second, new_hour, new_minute, slot_number
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status, event_res, ringing, ring_number, entry_count, entry_hour,
    // entry_minute
    output logic [31:0] m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    ctl_state_t state_reg, state_next;

    // captured command beat
    logic [2:0]        cmd_reg;
    logic [HOUR_W-1:0] hh_reg;
    logic [MIN_W-1:0]  mm_reg;
    logic [SEC_W-1:0]  ss_reg;
    logic [NEW_W-1:0]  nh_reg;
    logic [NEW_W-1:0]  nm_reg;
    logic [3:0]        num_reg;
    logic [SEC_W-1:0]  ss_in;

    // control state
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ring_reg, ring_next;
    logic              snz_reg, snz_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [SEC_W-1:0]  start_reg, start_next;
    logic [7:0]        left_reg, left_next;
    logic              hv_reg, hv_next;
    logic [HOUR_W-1:0] hh_done_reg, hh_done_next;
    logic [MIN_W-1:0]  mm_done_reg, mm_done_next;
    logic [HOUR_W-1:0] rhour_reg, rhour_next;
    logic [MIN_W-1:0]  rmin_reg, rmin_next;
    logic [5:0]        timeout_reg;
    logic [7:0]        snz_len_reg;

    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_data_reg, out_data_next;

    logic              commit;
    logic              busy, num_ok, hv_eff, have_read;
    logic [SEC_W:0]    elapsed;
    logic [2:0]        status, event_code;
    logic [HOUR_W-1:0] ent_hour;
    logic [MIN_W-1:0]  ent_minute;
    logic [3:0]        ring_num;
    tbl_req_t          tbl_req;
    tbl_rsp_t          tbl_rsp;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign commit   = (state_reg == S_EXEC) && (!out_valid_reg || m_tready);

    // clamp seconds 60..63 to 59
    assign ss_in = (s_tdata[19:14] > SEC_MAX) ? SEC_MAX : s_tdata[19:14];

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg <= s_tdata[2:0];
            hh_reg  <= s_tdata[7:3];
            mm_reg  <= s_tdata[13:8];
            ss_reg  <= ss_in;
            nh_reg  <= s_tdata[26:20];
            nm_reg  <= s_tdata[33:27];
            num_reg <= s_tdata[37:34];
        end
    end

    alsc_table u_table (
        .clk         (clk),
        .req         (tbl_req),
        .count       (count_reg),
        .load_hour   (nh_reg[HOUR_W-1:0]),
        .load_minute (nm_reg[MIN_W-1:0]),
        .cmp_hour    (hh_reg),
        .cmp_minute  (mm_reg),
        .rd_idx      (IDX_W'(num_reg - 4'd1)),
        .rsp         (tbl_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (commit)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        count_next   = count_reg;
        ring_next    = ring_reg;
        snz_next     = snz_reg;
        slot_next    = slot_reg;
        start_next   = start_reg;
        left_next    = left_reg;
        hv_next      = hv_reg;
        hh_done_next = hh_done_reg;
        mm_done_next = mm_done_reg;
        rhour_next   = rhour_reg;
        rmin_next    = rmin_reg;
        status       = ST_OK;
        event_code   = EV_NONE;
        have_read    = 1'b0;
        tbl_req      = '0;

        busy   = ring_reg || snz_reg;
        num_ok = (num_reg != 4'd0) && (num_reg <= count_reg);
        hv_eff = hv_reg && (hh_reg == hh_done_reg) && (mm_reg == mm_done_reg);
        if (ss_reg >= start_reg)
            elapsed = {1'b0, ss_reg - start_reg};
        else
            elapsed = SEC_PER_MIN - {1'b0, start_reg} + {1'b0, ss_reg};

        unique case (cmd_reg)
            CMD_TICK:
            begin
                if (ring_reg)
                begin
                    if (elapsed >= {1'b0, timeout_reg})
                    begin
                        hv_next      = 1'b1;
                        hh_done_next = rhour_reg;
                        mm_done_next = rmin_reg;
                        ring_next    = 1'b0;
                        snz_next     = 1'b0;
                        slot_next    = '0;
                        event_code   = EV_TIMEOUT;
                    end
                end
                else if (snz_reg)
                begin
                    if (left_reg <= 8'd1)
                    begin
                        left_next  = '0;
                        snz_next   = 1'b0;
                        ring_next  = 1'b1;
                        start_next = ss_reg;
                        event_code = EV_RESUME;
                    end
                    else
                        left_next = left_reg - 8'd1;
                end
                else
                begin
                    // drop the handled mark once the clock leaves its minute
                    hv_next = hv_eff;
                    if (tbl_rsp.hit && !hv_eff)
                    begin
                        ring_next  = 1'b1;
                        slot_next  = tbl_rsp.hit_idx;
                        start_next = ss_reg;
                        rhour_next = hh_reg;
                        rmin_next  = mm_reg;
                        event_code = EV_START;
                    end
                end
            end
            CMD_ADD:
            begin
                if (busy)
                    status = ST_BUSY;
                else if (count_reg >= CNT_W'(SLOT_COUNT))
                    status = ST_FULL;
                else if ((nh_reg >= HOURS_PER_DAY) || (nm_reg >= MIN_PER_HOUR))
                    status = ST_BADTIME;
                else
                begin
                    tbl_req.append = 1'b1;
                    tbl_req.pos    = IDX_W'(count_reg);
                    count_next     = count_reg + 4'd1;
                end
            end
            CMD_DEL:
            begin
                if (busy)
                    status = ST_BUSY;
                else if (!num_ok)
                    status = ST_BADNUM;
                else
                begin
                    tbl_req.remove = 1'b1;
                    tbl_req.pos    = IDX_W'(num_reg - 4'd1);
                    count_next     = count_reg - 4'd1;
                end
            end
            CMD_OFF:
            begin
                if (ring_reg)
                begin
                    hv_next      = 1'b1;
                    hh_done_next = rhour_reg;
                    mm_done_next = rmin_reg;
                    ring_next    = 1'b0;
                    snz_next     = 1'b0;
                    slot_next    = '0;
                    event_code   = EV_KEY;
                end
            end
            CMD_SNOOZE:
            begin
                if (ring_reg)
                begin
                    ring_next  = 1'b0;
                    snz_next   = 1'b1;
                    left_next  = snz_len_reg;
                    event_code = EV_SNOOZE;
                end
            end
            CMD_READ:
            begin
                if (!num_ok)
                    status = ST_BADNUM;
                else
                    have_read = 1'b1;
            end
            default:
                status = ST_OK;
        endcase

        // no table edit unless this cycle retires the command
        if (!commit)
            tbl_req = '0;

        if (have_read)
        begin
            ent_hour   = tbl_rsp.rd_hour;
            ent_minute = tbl_rsp.rd_minute;
        end
        else if (ring_next || snz_next)
        begin
            ent_hour   = rhour_next;
            ent_minute = rmin_next;
        end
        else
        begin
            ent_hour   = '0;
            ent_minute = '0;
        end
        ring_num = (ring_next || snz_next) ? (4'(slot_next) + 4'd1) : 4'd0;

        out_data_next = {6'd0, ent_minute, ent_hour, count_next, ring_num,
                         ring_next, event_code, status};

        if (commit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            ring_reg      <= 1'b0;
            snz_reg       <= 1'b0;
            slot_reg      <= '0;
            start_reg     <= '0;
            left_reg      <= '0;
            hv_reg        <= 1'b0;
            hh_done_reg   <= '0;
            mm_done_reg   <= '0;
            rhour_reg     <= '0;
            rmin_reg      <= '0;
            timeout_reg   <= TIMEOUT_RESET;
            snz_len_reg   <= SNOOZE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                count_reg   <= count_next;
                ring_reg    <= ring_next;
                snz_reg     <= snz_next;
                slot_reg    <= slot_next;
                start_reg   <= start_next;
                left_reg    <= left_next;
                hv_reg      <= hv_next;
                hh_done_reg <= hh_done_next;
                mm_done_reg <= mm_done_next;
                rhour_reg   <= rhour_next;
                rmin_reg    <= rmin_next;
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_TIMEOUT)
                    timeout_reg <= cfg_data[5:0];
                else if (cfg_index == REG_SNOOZE)
                    snz_len_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
            out_data_reg <= out_data_next;
    end

endmodule

/* hdl/alsc_checker.sv */
// ---------------------------------------------------------------------------
// alsc_checker: port-level checks for the alarm scheduler
// Watches the command and result channels and the fields of result beats.
// ---------------------------------------------------------------------------
module alsc_checker
    import alsc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    logic [2:0] ev;
    logic       ringing;
    logic [3:0] rnum;
    logic [3:0] cnt;

    assign ev      = m_tdata[OUT_EVENT_LSB +: 3];
    assign ringing = m_tdata[OUT_RING_BIT];
    assign rnum    = m_tdata[OUT_RNUM_LSB +: 4];
    assign cnt     = m_tdata[OUT_COUNT_LSB +: 4];

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one command in flight at a time
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken while another is in flight");

    a_ring_num: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ringing |-> (rnum != 4'd0) && (rnum <= cnt))
        else $error("ringing without a valid entry number");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> cnt <= CNT_W'(SLOT_COUNT))
        else $error("entry count beyond table size");

    a_start_rings: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((ev == EV_START) || (ev == EV_RESUME)) |-> ringing)
        else $error("ring start or resume reported while not ringing");

endmodule

bind multi_slot_alarm_scheduler alsc_checker u_alsc_checker (.*);
